>>> rtl/core/rsc_pkg.sv
// shared constants, register codes and control types for the rgb stencil convolution
package rsc_pkg;

  localparam int SUM_BITS          = 17;
  localparam int TAP_BITS          = 4;
  localparam int NUM_TAPS          = 25;
  localparam int NUM_CHANNELS      = 3;
  localparam int CH_RED            = 0;
  localparam int CH_GREEN          = 1;
  localparam int CH_BLUE           = 2;

  localparam int CFG_INDEX_BITS    = 3;
  localparam int CFG_DATA_BITS     = 64;
  localparam int FRAME_WIDTH_BITS  = 11;
  localparam int FRAME_HEIGHT_BITS = 16;
  localparam int KERNEL_BITS       = 3;
  localparam int COEFF_FIRST_BITS  = 64;
  localparam int COEFF_SECOND_BITS = 36;
  localparam int COEFF_ALL_BITS    = COEFF_FIRST_BITS + COEFF_SECOND_BITS;

  localparam logic [FRAME_WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd1024;
  localparam logic [FRAME_HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd512;
  localparam logic [KERNEL_BITS-1:0]       KERNEL_SIZE_RESET  = 3'd3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_SIZE   = 3'd2,
    REG_COEFFS_FIRST  = 3'd3,
    REG_COEFFS_SECOND = 3'd4
  } cfg_reg_t;

  // pipeline tag that travels with each item
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } stage_tag_t;

  // controls from the pipeline sequencer to the window datapath
  typedef struct packed {
    logic shift;
    logic advance;
  } win_ctl_t;

endpackage

>>> rtl/core/rsc_line_store.sv
// line store memory: one word per column holding the samples of earlier rows
module rsc_line_store #(
  parameter int DEPTH     = 1024,
  parameter int WORD_BITS = 96
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WORD_BITS-1:0]       rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WORD_BITS-1:0]       wr_data
);
  import rsc_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  // write-first forwarding covers a one-column frame
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/rsc_tap_grid.sv
// maps the packed coefficient registers onto the window positions for the active kernel
module rsc_tap_grid #(
  parameter int MAX_KERNEL = 5
) (
  input  logic                                     clk,
  input  logic [rsc_pkg::COEFF_FIRST_BITS-1:0]     coeffs_first,
  input  logic [rsc_pkg::COEFF_SECOND_BITS-1:0]    coeffs_second,
  input  logic [rsc_pkg::KERNEL_BITS-1:0]          kernel,
  output logic signed [rsc_pkg::TAP_BITS-1:0]      taps [MAX_KERNEL][MAX_KERNEL]
);
  import rsc_pkg::*;

  localparam int MK = MAX_KERNEL;

  logic signed [TAP_BITS-1:0] taps_next [MK][MK];

  // kernel sits in the bottom-right corner of the window, taps in raster order
  always_comb begin
    int t;
    logic [COEFF_ALL_BITS-1:0] coeff_all;
    coeff_all = {coeffs_second, coeffs_first};
    t = 0;
    for (int y = 0; y < MK; y++) begin
      for (int x = 0; x < MK; x++) begin
        taps_next[y][x] = '0;
        for (int kk = 1; kk <= MK; kk += 2) begin
          if ((y >= MK - kk) && (x >= MK - kk)) begin
            t = (y - (MK - kk)) * kk + (x - (MK - kk));
            if ((kernel == KERNEL_BITS'(kk)) && (t < NUM_TAPS)) begin
              taps_next[y][x] = coeff_all[TAP_BITS*t +: TAP_BITS];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    taps <= taps_next;
  end

endmodule

>>> rtl/core/rsc_window_sum.sv
// pixel window registers, per-row products and the per-channel sum
module rsc_window_sum #(
  parameter int MAX_KERNEL  = 5,
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                  clk,
  input  rsc_pkg::win_ctl_t                     ctl,
  input  logic [3*SAMPLE_BITS-1:0]              column [MAX_KERNEL],
  input  logic signed [rsc_pkg::TAP_BITS-1:0]   taps [MAX_KERNEL][MAX_KERNEL],
  output logic signed [rsc_pkg::SUM_BITS-1:0]   sums [rsc_pkg::NUM_CHANNELS]
);
  import rsc_pkg::*;

  localparam int MK = MAX_KERNEL;
  localparam int PB = 3 * SAMPLE_BITS;

  logic [PB-1:0]              window   [MK][MK];
  logic signed [SUM_BITS-1:0] row_sum  [NUM_CHANNELS][MK];
  logic signed [SUM_BITS-1:0] row_next [NUM_CHANNELS][MK];

  // shift left, newest column enters on the right
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int y = 0; y < MK; y++) begin
        for (int x = 0; x < MK - 1; x++) begin
          window[y][x] <= window[y][x+1];
        end
        window[y][MK-1] <= column[y];
      end
    end
  end

  // products skipped where the tap is zero, so stale samples never leak in
  always_comb begin
    logic signed [SAMPLE_BITS:0]          smp;
    logic signed [SAMPLE_BITS+TAP_BITS:0] prod;
    logic signed [SUM_BITS-1:0]           acc;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      for (int y = 0; y < MK; y++) begin
        acc = '0;
        for (int x = 0; x < MK; x++) begin
          smp  = signed'({1'b0, window[y][x][c*SAMPLE_BITS +: SAMPLE_BITS]});
          prod = smp * taps[y][x];
          if (taps[y][x] != '0) begin
            acc = acc + SUM_BITS'(prod);
          end
        end
        row_next[c][y] = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      row_sum <= row_next;
    end
  end

  always_comb begin
    logic signed [SUM_BITS-1:0] acc;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      acc = '0;
      for (int y = 0; y < MK; y++) begin
        acc = acc + row_sum[c][y];
      end
      sums[c] = acc;
    end
  end

endmodule

>>> rtl/core/rgb_stencil_convolution.sv
// top level of the rgb stencil convolution: config, counters, pipeline control
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  config   | cfg_write             | cfg_index, cfg_data
//  pixel in | in_valid / in_ready   | red_in, green_in, blue_in
//  sum out  | out_valid / out_ready | red_sum, green_sum, blue_sum, frame_end
//
// one pixel per clock sustained while the output is not stalled
// four stages: line store read, window shift, row products, final sum register
// line store is a one-read one-write memory, one word per column; no clearing pass
// rst is synchronous and clears counters, valids and config registers to reset values
// a stalled output freezes every stage at once, so in_ready follows out_ready while a result waits
module rgb_stencil_convolution #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_KERNEL  = 5,
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [rsc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rsc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SAMPLE_BITS-1:0]                red_in,
  input  logic [SAMPLE_BITS-1:0]                green_in,
  input  logic [SAMPLE_BITS-1:0]                blue_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rsc_pkg::SUM_BITS-1:0]   red_sum,
  output logic signed [rsc_pkg::SUM_BITS-1:0]   green_sum,
  output logic signed [rsc_pkg::SUM_BITS-1:0]   blue_sum,
  output logic                                  frame_end
);
  import rsc_pkg::*;

  localparam int MK    = MAX_KERNEL;
  localparam int PB    = 3 * SAMPLE_BITS;
  localparam int CW    = $clog2(MAX_WIDTH);
  // rows kept per column; at least one so the store always exists
  localparam int LINES = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
  localparam int LW    = LINES * PB;

  // configuration registers
  logic [FRAME_WIDTH_BITS-1:0]  frame_width;
  logic [FRAME_HEIGHT_BITS-1:0] frame_height;
  logic [KERNEL_BITS-1:0]       kernel_size;
  logic [COEFF_FIRST_BITS-1:0]  coeffs_first;
  logic [COEFF_SECOND_BITS-1:0] coeffs_second;

  // effective geometry
  logic [KERNEL_BITS-1:0]       eff_kernel;
  logic [KERNEL_BITS-1:0]       kernel_m1;
  logic [CW-1:0]                width_m1;
  logic [FRAME_HEIGHT_BITS-1:0] height_m1;

  // raster position of the next item
  logic [CW-1:0]                col_count;
  logic [FRAME_HEIGHT_BITS-1:0] row_count;

  logic       stall_free;
  logic       accept;
  logic       restart;
  logic       emit;
  logic       last;

  stage_tag_t s1;
  stage_tag_t s2;
  stage_tag_t s3;
  logic [PB-1:0] s1_pix;
  logic [CW-1:0] s1_col;

  logic [LW-1:0] line_rd;
  logic [LW-1:0] line_wr;
  logic [PB-1:0] column [MK];

  logic signed [TAP_BITS-1:0] taps [MK][MK];
  logic signed [SUM_BITS-1:0] win_sums [NUM_CHANNELS];
  win_ctl_t                   win_ctl;

  // whole pipeline moves together unless a result waits at the output
  assign stall_free = !out_valid || out_ready;
  assign in_ready   = stall_free;
  assign accept     = in_valid && stall_free;

  assign restart = cfg_write && ((cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH) ||
                                 (cfg_reg_t'(cfg_index) == REG_FRAME_HEIGHT) ||
                                 (cfg_reg_t'(cfg_index) == REG_KERNEL_SIZE));

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RESET;
      frame_height  <= FRAME_HEIGHT_RESET;
      kernel_size   <= KERNEL_SIZE_RESET;
      coeffs_first  <= '0;
      coeffs_second <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[FRAME_WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[FRAME_HEIGHT_BITS-1:0];
        REG_KERNEL_SIZE:   kernel_size   <= cfg_data[KERNEL_BITS-1:0];
        REG_COEFFS_FIRST:  coeffs_first  <= cfg_data[COEFF_FIRST_BITS-1:0];
        REG_COEFFS_SECOND: coeffs_second <= cfg_data[COEFF_SECOND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // kernel clipped to the window size and forced odd
  always_comb begin
    logic [KERNEL_BITS-1:0] k;
    k = kernel_size;
    if (32'(kernel_size) > MAX_KERNEL) begin
      k = KERNEL_BITS'(MAX_KERNEL);
    end
    if (!k[0]) begin
      k = (k == '0) ? KERNEL_BITS'(1) : k - KERNEL_BITS'(1);
    end
    eff_kernel = k;
  end

  assign kernel_m1 = eff_kernel - KERNEL_BITS'(1);

  // zero width acts as one, oversize width is clipped
  always_comb begin
    if (frame_width == '0) begin
      width_m1 = '0;
    end else if (32'(frame_width) > MAX_WIDTH) begin
      width_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      width_m1 = CW'(frame_width - FRAME_WIDTH_BITS'(1));
    end
  end

  assign height_m1 = (frame_height == '0) ? '0 : frame_height - FRAME_HEIGHT_BITS'(1);

  // a result once the full kernel lies inside the frame
  assign emit = (32'(row_count) >= 32'(kernel_m1)) && (32'(col_count) >= 32'(kernel_m1));
  assign last = (row_count == height_m1) && (col_count == width_m1);

  // raster counters, restarted by any geometry write
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_count == width_m1) begin
        col_count <= '0;
        row_count <= (row_count == height_m1) ? '0 : row_count + FRAME_HEIGHT_BITS'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // stage 1: pixel and its column word from the line store
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (stall_free) begin
      s1.valid <= accept;
      s1.emit  <= emit;
      s1.last  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= {blue_in, green_in, red_in};
      s1_col <= col_count;
    end
  end

  rsc_line_store #(
    .DEPTH     (MAX_WIDTH),
    .WORD_BITS (LW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (line_rd),
    .wr_en   (stall_free && s1.valid),
    .wr_addr (s1_col),
    .wr_data (line_wr)
  );

  // new window column top to bottom, and the column word pushed down by one row
  always_comb begin
    column[MK-1] = s1_pix;
    for (int d = 1; d < MK; d++) begin
      column[MK-1-d] = line_rd[(d-1)*PB +: PB];
    end
    line_wr[PB-1:0] = s1_pix;
    for (int d = 1; d < LINES; d++) begin
      line_wr[d*PB +: PB] = line_rd[(d-1)*PB +: PB];
    end
  end

  rsc_tap_grid #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_tap_grid (
    .clk           (clk),
    .coeffs_first  (coeffs_first),
    .coeffs_second (coeffs_second),
    .kernel        (eff_kernel),
    .taps          (taps)
  );

  assign win_ctl.shift   = stall_free && s1.valid;
  assign win_ctl.advance = stall_free;

  rsc_window_sum #(
    .MAX_KERNEL  (MAX_KERNEL),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window_sum (
    .clk    (clk),
    .ctl    (win_ctl),
    .column (column),
    .taps   (taps),
    .sums   (win_sums)
  );

  // stage 2 holds the window, stage 3 the row sums; only emitting items carry on
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
      s3 <= '0;
    end else if (stall_free) begin
      s2.valid <= s1.valid && s1.emit;
      s2.emit  <= s1.emit;
      s2.last  <= s1.last;
      s3.valid <= s2.valid && s2.emit;
      s3.emit  <= s2.emit;
      s3.last  <= s2.last;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stall_free) begin
      out_valid <= s3.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stall_free && s3.valid) begin
      red_sum   <= win_sums[CH_RED];
      green_sum <= win_sums[CH_GREEN];
      blue_sum  <= win_sums[CH_BLUE];
      frame_end <= s3.last;
    end
  end

endmodule

>>> rtl/core/rsc_checker.sv
// port-level checks on the rgb stencil convolution, bound to its top level
module rsc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [rsc_pkg::SUM_BITS-1:0]  red_sum,
  input logic signed [rsc_pkg::SUM_BITS-1:0]  green_sum,
  input logic signed [rsc_pkg::SUM_BITS-1:0]  blue_sum,
  input logic                                 frame_end
);
  import rsc_pkg::*;

  // a result waiting at the output holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_sum) && $stable(green_sum) &&
                                $stable(blue_sum) && $stable(frame_end))
    else $error("result changed while stalled");

  // an empty output never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a stalled output freezes the pipeline
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind rgb_stencil_convolution rsc_checker u_rsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .red_sum   (red_sum),
  .green_sum (green_sum),
  .blue_sum  (blue_sum),
  .frame_end (frame_end)
);
